@@ rtl/csag_pkg.sv @@
// ----------------------------------------------------------------------------
// csag_pkg
// Shared types and constants of the channel shuffle address generator: the
// sequencer states, the shared arithmetic unit's operation and handshake
// structs, register indexes and input mode codes.
// ----------------------------------------------------------------------------
package csag_pkg;

  localparam int CFG_INDEX_BITS   = 2;
  localparam int CFG_DATA_BITS    = 16;
  localparam int POSITION_BITS    = 32;
  localparam int OUTER_COUNT_BITS = 16;
  localparam int RADIX_REG_BITS   = 13;

  localparam logic [CFG_INDEX_BITS-1:0] REG_OUTER_COUNT        = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNELS_PER_GROUP = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GROUP_COUNT        = 2'd2;

  localparam logic MODE_SEED    = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_GRP,
    ST_DIV_CPG,
    ST_DIV_OUT,
    ST_MUL_STRIDE,
    ST_MUL_BASE,
    ST_MUL_DEST,
    ST_MUL_SRC,
    ST_EMIT
  } csag_state_t;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } csag_alu_op_t;

  typedef struct packed {
    logic         start;
    csag_alu_op_t op;
  } csag_alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } csag_alu_sts_t;

endpackage

@@ rtl/csag_alu.sv @@
// ----------------------------------------------------------------------------
// csag_alu
// Shared bit-serial arithmetic unit: one adder serves either a shift-add
// multiply (one multiplier bit per cycle) or a restoring divide (one quotient
// bit per cycle). Done pulses for one cycle when the result is ready.
// ----------------------------------------------------------------------------
module csag_alu
  import csag_pkg::*;
#(
  parameter int DW = 32,
  parameter int MW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  csag_alu_req_t req,
  input  logic [DW-1:0] opa,
  input  logic [MW-1:0] opb,
  output csag_alu_sts_t sts,
  output logic [DW-1:0] quo,
  output logic [MW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  csag_alu_op_t  op_r;
  logic [DW-1:0] acc;
  logic [DW-1:0] sh;
  logic [MW-1:0] mb;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [MW:0]   trial;
  logic [DW:0]   add_a;
  logic [DW:0]   add_b;
  logic [DW+1:0] sum;
  logic          fits;
  logic [DW-1:0] acc_next;
  logic [DW-1:0] sh_next;
  logic [MW-1:0] mb_next;

  always_comb begin
    trial = {acc[MW-1:0], sh[DW-1]};
    if (op_r == ALU_DIV) begin
      add_a = (DW+1)'(trial);
      add_b = ~((DW+1)'(mb));
    end else begin
      add_a = {1'b0, acc};
      add_b = {1'b0, sh};
    end
    sum  = {1'b0, add_a} + {1'b0, add_b} + (DW+2)'(op_r == ALU_DIV);
    fits = sum[DW+1];
    if (op_r == ALU_DIV) begin
      acc_next = fits ? DW'(sum[MW-1:0]) : DW'(trial[MW-1:0]);
      sh_next  = {sh[DW-2:0], fits};
      mb_next  = mb;
    end else begin
      acc_next = mb[0] ? sum[DW-1:0] : acc;
      sh_next  = {sh[DW-2:0], 1'b0};
      mb_next  = mb >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op_r <= ALU_MUL;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op_r <= req.op;
        cnt  <= (req.op == ALU_DIV) ? CW'(DW) : CW'(MW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
      sh  <= opa;
      mb  <= opb;
    end else if (busy) begin
      acc <= acc_next;
      sh  <= sh_next;
      mb  <= mb_next;
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quo      = (op_r == ALU_DIV) ? sh : acc;
  assign rem      = acc[MW-1:0];

  a_start_idle: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("shared unit started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("shared unit done while still busy");
  a_busy_rise: assert property (@(posedge clk) disable iff (rst) $rose(busy) |-> $past(req.start))
    else $error("shared unit became busy without a start");

endmodule

@@ rtl/channel_shuffle_address_generator_unit.sv @@
// ----------------------------------------------------------------------------
// channel_shuffle_address_generator_unit
// Address generator for a channel shuffle: keeps a mixed-radix counter of
// outer, within-group and group digits and returns source and destination
// block indexes for each seed or advance transaction.
// ----------------------------------------------------------------------------
// Usage: write outer_count, channels_per_group and group_count on the cfg
// channel (ready whenever rst is low) while the block is idle. A seed
// transaction on the input channel splits position into digits; an advance
// transaction steps to the next destination block. Every input transaction
// yields one output transaction carrying source_block, dest_block and wrapped.
// An advance that does not roll the group digit is handled at the accept
// edge, so such items flow at one per cycle while the output slot is free.
// An advance that rolls the group digit recomposes the addresses with four
// bit-serial multiplies on the shared unit; a seed first adds three bit-serial
// divisions. DW is the larger of INDEX_BITS and 32, MW the widest radix or
// outer digit, at least 16.
// Reset sets all registers to 1 and all digits and positions to zero, and
// neither input channel is ready while rst is high. The output register
// holds its transaction while out_ready is low; one more input is taken
// meanwhile and its result waits inside until the slot frees.
// ----------------------------------------------------------------------------
module channel_shuffle_address_generator_unit
  import csag_pkg::*;
#(
  parameter int INDEX_BITS = 32,
  parameter int DIGIT_BITS = 12,
  parameter int OUTER_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      mode,
  input  logic [POSITION_BITS-1:0]  position,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [POSITION_BITS-1:0]  source_block,
  output logic [POSITION_BITS-1:0]  dest_block,
  output logic                      wrapped
);

  localparam int RB    = DIGIT_BITS + 1;
  localparam int MW0   = (RB > OUTER_COUNT_BITS) ? RB : OUTER_COUNT_BITS;
  localparam int MW    = (MW0 > OUTER_BITS) ? MW0 : OUTER_BITS;
  localparam int DW    = (INDEX_BITS > POSITION_BITS) ? INDEX_BITS : POSITION_BITS;
  localparam int CMP_W = (RB > RADIX_REG_BITS) ? RB : RADIX_REG_BITS;
  localparam int OCW   = (OUTER_BITS + 1 > OUTER_COUNT_BITS) ? OUTER_BITS + 1
                                                             : OUTER_COUNT_BITS;

  function automatic logic [RB-1:0] radix_eff(input logic [RADIX_REG_BITS-1:0] raw);
    logic [CMP_W-1:0] ext;
    logic [CMP_W-1:0] lim;
    ext = CMP_W'(raw);
    lim = CMP_W'(1) << DIGIT_BITS;
    if (raw == '0) begin
      return RB'(1);
    end else if (ext > lim) begin
      return RB'(lim);
    end
    return RB'(ext);
  endfunction

  logic [OUTER_COUNT_BITS-1:0] outer_count;
  logic [RADIX_REG_BITS-1:0]   channels_per_group;
  logic [RADIX_REG_BITS-1:0]   group_count;

  csag_state_t state;
  csag_state_t state_next;

  logic [OUTER_BITS-1:0] outer_digit;
  logic [DIGIT_BITS-1:0] within_digit;
  logic [DIGIT_BITS-1:0] group_digit;
  logic [INDEX_BITS-1:0] source_position;
  logic [INDEX_BITS-1:0] dest_position;
  logic [DW-1:0]         work;
  logic [DW-1:0]         base;
  logic                  wrap_pend;
  logic                  launched;

  logic [OUTER_COUNT_BITS-1:0] outer_eff;
  logic [RB-1:0]               cpg_eff;
  logic [RB-1:0]               grp_eff;
  logic [RB-1:0]               g_inc;
  logic [RB-1:0]               w_inc;
  logic [OCW-1:0]              o_inc;
  logic                        roll_g;
  logic                        roll_w;
  logic                        roll_o;
  logic                        accept;
  logic                        slot_free;
  logic                        load_fast;
  logic                        load_emit;
  logic [INDEX_BITS-1:0]       src_fast;
  logic [INDEX_BITS-1:0]       dest_fast;

  csag_alu_req_t alu_req;
  csag_alu_sts_t alu_sts;
  logic [DW-1:0] alu_opa;
  logic [MW-1:0] alu_opb;
  logic [DW-1:0] alu_quo;
  logic [MW-1:0] alu_rem;

  csag_alu #(
    .DW(DW),
    .MW(MW)
  ) u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .opa (alu_opa),
    .opb (alu_opb),
    .sts (alu_sts),
    .quo (alu_quo),
    .rem (alu_rem)
  );

  assign outer_eff = (outer_count == '0) ? OUTER_COUNT_BITS'(1) : outer_count;
  assign cpg_eff   = radix_eff(channels_per_group);
  assign grp_eff   = radix_eff(group_count);
  assign g_inc     = RB'(group_digit) + RB'(1);
  assign w_inc     = RB'(within_digit) + RB'(1);
  assign o_inc     = OCW'(outer_digit) + OCW'(1);
  assign roll_g    = !(g_inc < grp_eff);
  assign roll_w    = !(w_inc < cpg_eff);
  assign roll_o    = !(o_inc < OCW'(outer_eff));
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign src_fast  = INDEX_BITS'(DW'(source_position) + DW'(cpg_eff));
  assign dest_fast = dest_position + INDEX_BITS'(1);
  assign load_fast = accept && (mode == MODE_ADVANCE) && !roll_g && slot_free;
  assign load_emit = (state == ST_EMIT) && slot_free;
  assign cfg_ready = !rst;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode == MODE_SEED) begin
            state_next = ST_DIV_GRP;
          end else if (roll_g) begin
            state_next = ST_MUL_STRIDE;
          end else if (!slot_free) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_DIV_GRP:    if (alu_sts.done) state_next = ST_DIV_CPG;
      ST_DIV_CPG:    if (alu_sts.done) state_next = ST_DIV_OUT;
      ST_DIV_OUT:    if (alu_sts.done) state_next = ST_MUL_STRIDE;
      ST_MUL_STRIDE: if (alu_sts.done) state_next = ST_MUL_BASE;
      ST_MUL_BASE:   if (alu_sts.done) state_next = ST_MUL_DEST;
      ST_MUL_DEST:   if (alu_sts.done) state_next = ST_MUL_SRC;
      ST_MUL_SRC:    if (alu_sts.done) state_next = ST_EMIT;
      ST_EMIT:       if (slot_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    alu_req.start = 1'b0;
    alu_req.op    = ALU_MUL;
    alu_opa       = '0;
    alu_opb       = '0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
      end
      ST_DIV_GRP: begin
        alu_req.start = !launched;
        alu_req.op    = ALU_DIV;
        alu_opa       = work;
        alu_opb       = MW'(grp_eff);
      end
      ST_DIV_CPG: begin
        alu_req.start = !launched;
        alu_req.op    = ALU_DIV;
        alu_opa       = work;
        alu_opb       = MW'(cpg_eff);
      end
      ST_DIV_OUT: begin
        alu_req.start = !launched;
        alu_req.op    = ALU_DIV;
        alu_opa       = work;
        alu_opb       = MW'(outer_eff);
      end
      ST_MUL_STRIDE: begin
        alu_req.start = !launched;
        alu_opa       = DW'(cpg_eff);
        alu_opb       = MW'(grp_eff);
      end
      ST_MUL_BASE: begin
        alu_req.start = !launched;
        alu_opa       = work;
        alu_opb       = MW'(outer_digit);
      end
      ST_MUL_DEST: begin
        alu_req.start = !launched;
        alu_opa       = DW'(grp_eff);
        alu_opb       = MW'(within_digit);
      end
      ST_MUL_SRC: begin
        alu_req.start = !launched;
        alu_opa       = DW'(cpg_eff);
        alu_opb       = MW'(group_digit);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_count        <= OUTER_COUNT_BITS'(1);
      channels_per_group <= RADIX_REG_BITS'(1);
      group_count        <= RADIX_REG_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OUTER_COUNT:        outer_count        <= cfg_data;
        REG_CHANNELS_PER_GROUP: channels_per_group <= cfg_data[RADIX_REG_BITS-1:0];
        REG_GROUP_COUNT:        group_count        <= cfg_data[RADIX_REG_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      launched        <= 1'b0;
      outer_digit     <= '0;
      within_digit    <= '0;
      group_digit     <= '0;
      source_position <= '0;
      dest_position   <= '0;
      wrap_pend       <= 1'b0;
    end else begin
      state <= state_next;
      if (alu_req.start) begin
        launched <= 1'b1;
      end else if (alu_sts.done) begin
        launched <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            wrap_pend <= 1'b0;
            if (mode == MODE_SEED) begin
              work <= DW'(position);
            end else if (!roll_g) begin
              group_digit     <= g_inc[DIGIT_BITS-1:0];
              source_position <= src_fast;
              dest_position   <= dest_fast;
            end else begin
              group_digit <= '0;
              if (!roll_w) begin
                within_digit <= w_inc[DIGIT_BITS-1:0];
              end else begin
                within_digit <= '0;
                if (!roll_o) begin
                  outer_digit <= o_inc[OUTER_BITS-1:0];
                end else begin
                  outer_digit <= '0;
                  wrap_pend   <= 1'b1;
                end
              end
            end
          end
        end
        ST_DIV_GRP: begin
          if (alu_sts.done) begin
            group_digit <= alu_rem[DIGIT_BITS-1:0];
            work        <= alu_quo;
          end
        end
        ST_DIV_CPG: begin
          if (alu_sts.done) begin
            within_digit <= alu_rem[DIGIT_BITS-1:0];
            work         <= alu_quo;
          end
        end
        ST_DIV_OUT: begin
          if (alu_sts.done) outer_digit <= alu_rem[OUTER_BITS-1:0];
        end
        ST_MUL_STRIDE: begin
          if (alu_sts.done) work <= alu_quo;
        end
        ST_MUL_BASE: begin
          if (alu_sts.done) base <= alu_quo;
        end
        ST_MUL_DEST: begin
          if (alu_sts.done) begin
            dest_position <= INDEX_BITS'(base + alu_quo + DW'(group_digit));
          end
        end
        ST_MUL_SRC: begin
          if (alu_sts.done) begin
            source_position <= INDEX_BITS'(base + alu_quo + DW'(within_digit));
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_fast || load_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fast) begin
      source_block <= POSITION_BITS'(DW'(src_fast));
      dest_block   <= POSITION_BITS'(DW'(dest_fast));
      wrapped      <= 1'b0;
    end else if (load_emit) begin
      source_block <= POSITION_BITS'(DW'(source_position));
      dest_block   <= POSITION_BITS'(DW'(dest_position));
      wrapped      <= wrap_pend;
    end
  end

  a_ready_alu_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !alu_sts.busy)
    else $error("input ready while the shared unit is busy");
  a_done_launched: assert property (@(posedge clk) disable iff (rst)
    alu_sts.done |-> launched)
    else $error("shared unit result without a launch");
  a_seed_divides: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_SEED) |=> state == ST_DIV_GRP)
    else $error("seed transaction did not start the division sequence");
  a_wrap_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && wrapped) |-> (source_block == '0 && dest_block == '0))
    else $error("wrapped transaction with nonzero addresses");

endmodule
